// ===== design/wpf_pkg.sv =====
// Shared constants, types and microprogram for the word polynomial fingerprint unit.
package wpf_pkg;

  // Field and datapath widths
  localparam int unsigned CharW  = 7;
  localparam int unsigned HashW  = 30;
  localparam int unsigned CountW = 32;
  localparam int unsigned BaseW  = 8;
  // acc*base + add stays below 131*PRIME < 2**37
  localparam int unsigned ProdW  = 37;
  // remainder after the quotient estimate stays below 2*PRIME
  localparam int unsigned RemW   = 31;
  localparam int unsigned HiShift = 29;
  localparam int unsigned QuotW  = ProdW - HiShift;
  localparam int unsigned RecipW = 16;
  localparam int unsigned StepW  = 4;

  localparam logic [HashW-1:0] PRIME     = 30'd1000000801;
  localparam logic [BaseW-1:0] BASE_WORD = 8'd130;
  localparam logic [BaseW-1:0] BASE_LEN  = 8'd39;
  // floor(2**45 / PRIME): quotient estimate never exceeds the true quotient
  // and falls short of it by at most one
  localparam logic [RecipW-1:0] RECIP    = 16'd35184;

  localparam logic [CharW-1:0] CH_TAB   = 7'd9;
  localparam logic [CharW-1:0] CH_CR    = 7'd13;
  localparam logic [CharW-1:0] CH_SPACE = 7'd32;

  // Jump conditions of a control word
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_WORD_CHAR,
    COND_FINISH,
    COND_DOC_END
  } cond_t;

  // Multiply-add operations of the shared modular unit
  typedef enum logic [2:0] {
    OP_NONE,
    OP_CHAR,
    OP_LEN_HASH,
    OP_KEY_HASH,
    OP_PAIR,
    OP_PAIR_HASH
  } op_t;

  // Writeback targets of the modular unit
  typedef enum logic [2:0] {
    DST_NONE,
    DST_WORD,
    DST_LEN_HASH,
    DST_KEY_HASH,
    DST_PAIR,
    DST_PAIR_HASH
  } dst_t;

  // One control word: when cond fails, go to target (or end); else execute
  typedef struct packed {
    cond_t            cond;
    logic [StepW-1:0] target;
    logic             fail_end;
    op_t              op;
    logic             clr_word;
    logic             emit;
    logic             last;
  } ucode_t;

  localparam logic [StepW-1:0] STEP_FINISH = StepW'(4);
  localparam logic [StepW-1:0] STEP_EMIT   = StepW'(15);

  function automatic logic is_space(input logic [CharW-1:0] c);
    is_space = ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  // Microprogram: character fold, word finish, fingerprint emit
  function automatic ucode_t ucode_rom(input logic [StepW-1:0] step);
    ucode_t w;
    w = '{cond: COND_ALWAYS, target: '0, fail_end: 1'b0, op: OP_NONE,
          clr_word: 1'b0, emit: 1'b0, last: 1'b0};
    unique case (step)
      StepW'(0): begin
        w.cond   = COND_WORD_CHAR;
        w.target = STEP_FINISH;
        w.op     = OP_CHAR;
      end
      StepW'(4): begin
        w.cond   = COND_FINISH;
        w.target = STEP_EMIT;
        w.op     = OP_LEN_HASH;
      end
      StepW'(5): w.op = OP_KEY_HASH;
      StepW'(6): w.op = OP_PAIR;
      StepW'(7): w.clr_word = 1'b1;
      StepW'(10): w.op = OP_PAIR_HASH;
      StepW'(15): begin
        w.cond     = COND_DOC_END;
        w.fail_end = 1'b1;
        w.emit     = 1'b1;
        w.last     = 1'b1;
      end
      default: w.op = OP_NONE;
    endcase
    ucode_rom = w;
  endfunction

endpackage

// ===== design/wpf_if.sv =====
// Handshake interfaces for the input character channel and the fingerprint channel.
interface wpf_in_if;
  import wpf_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             has_char;
  logic             doc_end;
  modport source(output valid, char_code, has_char, doc_end, input ready);
  modport sink(input valid, char_code, has_char, doc_end, output ready);
endinterface

interface wpf_out_if;
  import wpf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] word_count;
  logic [HashW-1:0]  length_hash;
  logic [HashW-1:0]  word_key_hash;
  logic [HashW-1:0]  key_length_hash;
  modport source(output valid, word_count, length_hash, word_key_hash, key_length_hash,
                 input ready);
  modport sink(input valid, word_count, length_hash, word_key_hash, key_length_hash,
               output ready);
endinterface

// ===== design/word_polynomial_fingerprint_unit.sv =====
// Top level: microcoded word fingerprint engine with a shared modular multiply-add unit.
//
//   channel  | dir | fields                                               | handshake
//   ---------+-----+------------------------------------------------------+-------------
//   in_bus   | in  | char_code[6:0], has_char, doc_end                    | valid/ready
//   out_bus  | out | word_count[31:0], length_hash, word_key_hash,        | valid/ready
//            |     | key_length_hash (30 bits each)                       |
//
// One word at a time: a new input word is accepted only once the microprogram is done
// with the last one, and a document end may also wait on the output. All hash updates
// share the four-stage modular multiply-add unit (product, quotient estimate, subtract,
// correct). Reset is synchronous, active low, and clears all hash state. The
// result sits in an output register; a new word is taken while it waits, and only the
// emit step stalls when the previous fingerprint has not yet been taken.
module word_polynomial_fingerprint_unit (
  input  logic            clk,
  input  logic            rst_n,
  wpf_in_if.sink          in_bus,
  wpf_out_if.source       out_bus
);
  import wpf_pkg::*;

  // Sequencer state
  logic             busy_r, busy_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  // Latched input word
  logic [CharW-1:0] char_r;
  logic             has_char_r;
  logic             doc_end_r;

  // Fingerprint state
  logic [HashW-1:0]  wh_r, wh_nxt;
  logic [HashW-1:0]  len_r, len_nxt;
  logic              in_word_r, in_word_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [HashW-1:0]  rlh_r, rlh_nxt;
  logic [HashW-1:0]  rkh_r, rkh_nxt;
  logic [HashW-1:0]  pair_r, pair_nxt;
  logic [HashW-1:0]  rklh_r, rklh_nxt;

  // Modular unit pipeline
  logic [ProdW-1:0] t_r, t2_r;
  logic [QuotW-1:0] q_r;
  logic [RemW-1:0]  r_r;
  dst_t             dst1_r, dst2_r, dst3_r, dst_sel;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [CountW-1:0] out_count_r;
  logic [HashW-1:0]  out_lh_r, out_kh_r, out_klh_r;

  ucode_t           uc;
  logic             cond_ok;
  logic             exec;
  logic             stall;
  logic             fire_emit;
  logic             word_char;
  logic [HashW-1:0] acc_sel, add_sel;
  logic [BaseW-1:0] base_sel;
  logic [ProdW-1:0] t_nxt;
  logic [QuotW+RecipW-1:0] q_prod;
  logic [RemW-1:0]  r_nxt;
  logic [HashW-1:0] fin;
  logic [HashW-1:0] len_inc;

  assign in_bus.ready = !busy_r;
  assign uc           = ucode_rom(step_r);
  assign word_char    = has_char_r && !is_space(char_r);

  // Evaluate the step condition
  always_comb begin
    case (uc.cond)
      COND_WORD_CHAR: cond_ok = word_char;
      COND_FINISH:    cond_ok = in_word_r && (doc_end_r || (has_char_r && !word_char));
      COND_DOC_END:   cond_ok = doc_end_r;
      default:        cond_ok = 1'b1;
    endcase
  end

  assign exec      = busy_r && cond_ok;
  assign stall     = exec && uc.emit && out_valid_r && !out_bus.ready;
  assign fire_emit = exec && uc.emit && !stall;

  // Advance the step counter or take the jump
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (!busy_r) begin
      if (in_bus.valid) begin
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (!stall) begin
      if (!cond_ok) begin
        if (uc.fail_end) busy_nxt = 1'b0;
        else step_nxt = uc.target;
      end else if (uc.last) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + StepW'(1);
      end
    end
  end

  // Select operands of the multiply-add
  always_comb begin
    acc_sel  = '0;
    base_sel = BASE_LEN;
    add_sel  = '0;
    dst_sel  = DST_NONE;
    if (exec) begin
      case (uc.op)
        OP_CHAR: begin
          acc_sel  = wh_r;
          base_sel = BASE_WORD;
          add_sel  = HashW'(char_r);
          dst_sel  = DST_WORD;
        end
        OP_LEN_HASH: begin
          acc_sel = rlh_r;
          add_sel = len_r;
          dst_sel = DST_LEN_HASH;
        end
        OP_KEY_HASH: begin
          acc_sel = rkh_r;
          add_sel = wh_r;
          dst_sel = DST_KEY_HASH;
        end
        OP_PAIR: begin
          acc_sel = wh_r;
          add_sel = len_r;
          dst_sel = DST_PAIR;
        end
        OP_PAIR_HASH: begin
          acc_sel  = rklh_r;
          base_sel = BASE_WORD;
          add_sel  = pair_r;
          dst_sel  = DST_PAIR_HASH;
        end
        default: dst_sel = DST_NONE;
      endcase
    end
  end

  // Modular unit datapath: product, quotient estimate, subtract, correct
  assign t_nxt  = ProdW'(acc_sel) * ProdW'(base_sel) + ProdW'(add_sel);
  assign q_prod = (QuotW+RecipW)'(t_r[ProdW-1:HiShift]) * (QuotW+RecipW)'(RECIP);
  assign r_nxt  = RemW'(t2_r - ProdW'(q_r) * ProdW'(PRIME));
  assign fin    = (r_r >= RemW'(PRIME)) ? HashW'(r_r - RemW'(PRIME)) : HashW'(r_r);

  assign len_inc = (len_r + HashW'(1) >= PRIME) ? '0 : len_r + HashW'(1);

  // Update fingerprint state
  always_comb begin
    wh_nxt      = wh_r;
    len_nxt     = len_r;
    in_word_nxt = in_word_r;
    count_nxt   = count_r;
    rlh_nxt     = rlh_r;
    rkh_nxt     = rkh_r;
    pair_nxt    = pair_r;
    rklh_nxt    = rklh_r;
    // write back the unit result
    case (dst3_r)
      DST_WORD:      wh_nxt   = fin;
      DST_LEN_HASH:  rlh_nxt  = fin;
      DST_KEY_HASH:  rkh_nxt  = fin;
      DST_PAIR:      pair_nxt = fin;
      DST_PAIR_HASH: rklh_nxt = fin;
      default:       ;
    endcase
    // count the character into the word
    if (exec && (uc.op == OP_CHAR)) begin
      len_nxt     = len_inc;
      in_word_nxt = 1'b1;
    end
    // close the word
    if (exec && uc.clr_word) begin
      wh_nxt      = '0;
      len_nxt     = '0;
      in_word_nxt = 1'b0;
      count_nxt   = count_r + CountW'(1);
    end
    // drop all state once the fingerprint leaves
    if (fire_emit) begin
      wh_nxt      = '0;
      len_nxt     = '0;
      in_word_nxt = 1'b0;
      count_nxt   = '0;
      rlh_nxt     = '0;
      rkh_nxt     = '0;
      pair_nxt    = '0;
      rklh_nxt    = '0;
    end
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire_emit) out_valid_nxt = 1'b1;
    else if (out_bus.ready) out_valid_nxt = 1'b0;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      wh_r        <= '0;
      len_r       <= '0;
      in_word_r   <= 1'b0;
      count_r     <= '0;
      rlh_r       <= '0;
      rkh_r       <= '0;
      pair_r      <= '0;
      rklh_r      <= '0;
      dst1_r      <= DST_NONE;
      dst2_r      <= DST_NONE;
      dst3_r      <= DST_NONE;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      wh_r        <= wh_nxt;
      len_r       <= len_nxt;
      in_word_r   <= in_word_nxt;
      count_r     <= count_nxt;
      rlh_r       <= rlh_nxt;
      rkh_r       <= rkh_nxt;
      pair_r      <= pair_nxt;
      rklh_r      <= rklh_nxt;
      dst1_r      <= dst_sel;
      dst2_r      <= dst1_r;
      dst3_r      <= dst2_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!busy_r && in_bus.valid) begin
      char_r     <= in_bus.char_code;
      has_char_r <= in_bus.has_char;
      doc_end_r  <= in_bus.doc_end;
    end
    t_r  <= t_nxt;
    t2_r <= t_r;
    q_r  <= q_prod[QuotW+RecipW-1:RecipW];
    r_r  <= r_nxt;
    if (fire_emit) begin
      out_count_r <= count_r;
      out_lh_r    <= rlh_r;
      out_kh_r    <= rkh_r;
      out_klh_r   <= rklh_r;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.word_count      = out_count_r;
  assign out_bus.length_hash     = out_lh_r;
  assign out_bus.word_key_hash   = out_kh_r;
  assign out_bus.key_length_hash = out_klh_r;

endmodule

// ===== dv/wpf_tb_pkg.sv =====
`timescale 1ns / 100ps
// Fingerprint predictor and scoreboard for the word polynomial fingerprint unit.
package wpf_tb_pkg;
  import wpf_pkg::*;

  typedef struct packed {
    logic [CountW-1:0] word_count;
    logic [HashW-1:0]  length_hash;
    logic [HashW-1:0]  word_key_hash;
    logic [HashW-1:0]  key_length_hash;
  } fingerprint_t;

  localparam longint unsigned MODULUS   = 64'd1000000801;
  localparam int unsigned     CHAR_BASE = 130;
  localparam int unsigned     LEN_BASE  = 39;

  // Tab through carriage return, and space, separate words
  function automatic bit is_blank(input logic [CharW-1:0] c);
    return ((c >= 7'd9) && (c <= 7'd13)) || (c == 7'd32);
  endfunction

  class fingerprint_scoreboard;
    logic [HashW-1:0]  word_hash;
    logic [HashW-1:0]  word_len;
    logic [CountW-1:0] words;
    logic [HashW-1:0]  len_hash;
    logic [HashW-1:0]  key_hash;
    logic [HashW-1:0]  pair_hash;
    bit                in_word;
    fingerprint_t      expected_prints[$];
    int unsigned       mismatches;

    function new();
      clear_document();
      mismatches = 0;
    endfunction

    function void clear_document();
      word_hash = '0;
      word_len  = '0;
      words     = '0;
      len_hash  = '0;
      key_hash  = '0;
      pair_hash = '0;
      in_word   = 1'b0;
    endfunction

    // (acc*base + add) mod P in 64-bit arithmetic
    static function logic [HashW-1:0] mul_add_mod(input logic [HashW-1:0] acc,
                                                  input int unsigned base,
                                                  input logic [HashW-1:0] add);
      longint unsigned t;
      t = 64'(acc) * 64'(base) + 64'(add);
      return HashW'(t % MODULUS);
    endfunction

    // Fold the pending word into the running hashes
    function void close_word();
      logic [HashW-1:0] pair;
      if (!in_word) return;
      words     = words + 1'b1;
      len_hash  = mul_add_mod(len_hash, LEN_BASE, word_len);
      key_hash  = mul_add_mod(key_hash, LEN_BASE, word_hash);
      pair      = mul_add_mod(word_hash, LEN_BASE, word_len);
      pair_hash = mul_add_mod(pair_hash, CHAR_BASE, pair);
      word_hash = '0;
      word_len  = '0;
      in_word   = 1'b0;
    endfunction

    // Advance the predictor by one accepted input word
    function void note_char(input logic [CharW-1:0] c, input logic has_char,
                            input logic doc_end);
      fingerprint_t fp;
      if (has_char) begin
        if (is_blank(c)) begin
          close_word();
        end else begin
          word_hash = mul_add_mod(word_hash, CHAR_BASE, HashW'(c));
          if (64'(word_len) + 64'd1 >= MODULUS) word_len = '0;
          else word_len = word_len + 1'b1;
          in_word = 1'b1;
        end
      end
      if (doc_end) begin
        close_word();
        fp.word_count      = words;
        fp.length_hash     = len_hash;
        fp.word_key_hash   = key_hash;
        fp.key_length_hash = pair_hash;
        expected_prints    = {expected_prints, fp};
        clear_document();
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Compare one emitted fingerprint with the oldest expected one
    task check_fingerprint(input logic [CountW-1:0] word_count,
                           input logic [HashW-1:0] length_hash,
                           input logic [HashW-1:0] word_key_hash,
                           input logic [HashW-1:0] key_length_hash);
      fingerprint_t exp;
      if (expected_prints.size() == 0) begin
        report($sformatf("unexpected fingerprint count=%0d", word_count));
        return;
      end
      exp = expected_prints.pop_front();
      if (word_count !== exp.word_count)
        report($sformatf("word_count got %0d exp %0d", word_count, exp.word_count));
      if (length_hash !== exp.length_hash)
        report($sformatf("length_hash got %0d exp %0d", length_hash, exp.length_hash));
      if (word_key_hash !== exp.word_key_hash)
        report($sformatf("word_key_hash got %0d exp %0d", word_key_hash, exp.word_key_hash));
      if (key_length_hash !== exp.key_length_hash)
        report($sformatf("key_length_hash got %0d exp %0d",
                         key_length_hash, exp.key_length_hash));
    endtask

    task flag_missing();
      if (expected_prints.size() != 0)
        report($sformatf("%0d fingerprints never emitted", expected_prints.size()));
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives documents into the fingerprint unit and checks every fingerprint.
module tb_top;
  import wpf_pkg::*;
  import wpf_tb_pkg::*;

  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CALM_ITEMS  = 200;
  localparam int unsigned HOLD_AT     = 500;
  localparam int unsigned HOLD_CYCLES = 800;
  localparam int unsigned DRAIN       = 40;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;

  wpf_in_if  in_bus();
  wpf_out_if out_bus();

  word_polynomial_fingerprint_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  fingerprint_scoreboard sb = new();
  int unsigned chars_sent = 0;
  int unsigned cycles     = 0;
  bit          calm       = 1'b0;
  bit          gaps_on    = 1'b0;
  bit          hold_done  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each fingerprint taken from the block
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_fingerprint(out_bus.word_count, out_bus.length_hash,
                           out_bus.word_key_hash, out_bus.key_length_hash);
  end

  // Drive ready: random stall bursts, one long hold-off, none near the end
  initial begin : fingerprint_sink
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left    = 0;
    hold_left     = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && chars_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until the block takes it
  task automatic push_char(input logic [CharW-1:0] c, input logic has_char,
                           input logic doc_end);
    int unsigned gap;
    if (!calm && gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid     <= 1'b1;
    in_bus.char_code <= c;
    in_bus.has_char  <= has_char;
    in_bus.doc_end   <= doc_end;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_char(c, has_char, doc_end);
    chars_sent++;
  endtask

  function automatic logic [CharW-1:0] pick_blank();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 5))
      0:       c = 7'd9;
      1:       c = 7'd10;
      2:       c = 7'd11;
      3:       c = 7'd12;
      4:       c = 7'd13;
      default: c = 7'd32;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] pick_letter();
    logic [CharW-1:0] c;
    do c = 7'($urandom_range(0, 127)); while (is_blank(c));
    return c;
  endfunction

  // One random document: words split by blank runs, with stray empty words mixed in
  task automatic send_document();
    int unsigned nwords;
    int unsigned len;
    int unsigned k;
    gaps_on = ($urandom_range(0, 3) != 0);
    nwords  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 8);
    for (int w = 0; w < nwords; w++) begin
      k = (w == 0) ? $urandom_range(0, 2) : $urandom_range(1, 3);
      repeat (k) push_char(pick_blank(), 1'b1, 1'b0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) push_char(7'($urandom), 1'b0, 1'b0);
        push_char(pick_letter(), 1'b1, 1'b0);
      end
    end
    // Close on a letter, on a blank, or on an empty word
    case ($urandom_range(0, 3))
      0: push_char(pick_letter(), 1'b1, 1'b1);
      1: push_char(pick_blank(), 1'b1, 1'b1);
      default: begin
        repeat ($urandom_range(0, 2)) push_char(pick_blank(), 1'b1, 1'b0);
        push_char(7'($urandom), 1'b0, 1'b1);
      end
    endcase
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.char_code = '0;
    in_bus.has_char  = 1'b0;
    in_bus.doc_end   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty documents: bare end, and end on a blank after an ignored character
    push_char(7'd0, 1'b0, 1'b1);
    push_char(7'd127, 1'b0, 1'b0);
    push_char(7'd32, 1'b1, 1'b1);
    // Extreme codes, ended inside the word by an empty word
    push_char(7'd0, 1'b1, 1'b0);
    push_char(7'd127, 1'b1, 1'b0);
    push_char(7'd0, 1'b0, 1'b1);
    // Every blank code and the codes next to them
    push_char(7'd8, 1'b1, 1'b0);
    push_char(7'd9, 1'b1, 1'b0);
    push_char(7'd10, 1'b1, 1'b0);
    push_char(7'd11, 1'b1, 1'b0);
    push_char(7'd12, 1'b1, 1'b0);
    push_char(7'd13, 1'b1, 1'b0);
    push_char(7'd14, 1'b1, 1'b0);
    push_char(7'd31, 1'b1, 1'b0);
    push_char(7'd32, 1'b1, 1'b0);
    push_char(7'd33, 1'b1, 1'b0);
    push_char(7'd126, 1'b1, 1'b1);
    // Word closed by a blank carrying the end
    push_char(7'd65, 1'b1, 1'b0);
    push_char(7'd13, 1'b1, 1'b1);
    // Ignored character in the middle of a word
    push_char(7'd97, 1'b1, 1'b0);
    push_char(7'd120, 1'b0, 1'b0);
    push_char(7'd98, 1'b1, 1'b0);
    push_char(7'd32, 1'b0, 1'b1);

    while (chars_sent < ITEM_TARGET) begin
      calm = (chars_sent + CALM_ITEMS >= ITEM_TARGET);
      send_document();
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Drain every expected fingerprint, then let the block settle
    while (sb.expected_prints.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    sb.flag_missing();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
